>>> rtl/tlpt_pkg.sv
// Shared constants, codes and types of the two-level page table engine.
// Used by the controller, the datapath and the top level; no dependencies.
package tlpt_pkg;

  localparam int DIR_ENTRIES   = 1024;
  localparam int TABLE_ENTRIES = 1024;
  localparam int TABLE_POOL    = 16;

  localparam int IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W    = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int USED_W    = $clog2(TABLE_POOL + 1);
  localparam int TBL_AW    = SLOT_W + IDX_W;
  localparam int TBL_DEPTH = TABLE_POOL * TABLE_ENTRIES;

  localparam logic [31:0] FRAME_MASK    = 32'hFFFF_F000;
  localparam logic [31:0] OFFSET_MASK   = 32'h0000_0FFF;
  localparam logic [11:0] ENTRY_PRESENT = 12'h001;

  localparam logic [1:0] KIND_XLATE = 2'd0;
  localparam logic [1:0] KIND_MAP   = 2'd1;
  localparam logic [1:0] KIND_UNMAP = 2'd2;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_EMPTY,
    RES_XLATE,
    RES_UNMAP
  } res_sel_t;

  typedef struct packed {
    logic              present;
    logic [SLOT_W-1:0] slot;
  } dir_ent_t;

  typedef struct packed {
    logic     capture;
    logic     slot_ld;
    logic     alloc;
    logic     dir_init;
    logic     tbl_rd;
    logic     tbl_wr;
    logic     tbl_sweep;
    logic     tbl_map;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     res_ld;
    res_sel_t res_sel;
    logic     out_ld;
  } tlpt_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       dir_present;
    logic       pool_full;
    logic       cnt_last;
    logic       out_free;
  } tlpt_sts_t;

endpackage

>>> rtl/tlpt_if.sv
// Valid/ready channel interfaces for requests and results of the engine.
// Standalone; payload widths are fixed by the request and result formats.
interface tlpt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] vaddr;
  logic [31:0] paddr;
  logic [11:0] page_flags;

  modport source (output valid, kind, vaddr, paddr, page_flags, input ready);
  modport sink (input valid, kind, vaddr, paddr, page_flags, output ready);
endinterface

interface tlpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_addr;
  logic        frame_freed;
  logic        pool_empty;

  modport source (output valid, result_addr, frame_freed, pool_empty, input ready);
  modport sink (input valid, result_addr, frame_freed, pool_empty, output ready);
endinterface

>>> rtl/tlpt_datapath.sv
// Datapath: request registers, directory and table memories, pool counter,
// sweep counter and the result/output registers. Depends on tlpt_pkg.
module tlpt_datapath
  import tlpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  tlpt_cmd_t   cmd,
  output tlpt_sts_t   sts,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_vaddr,
  input  logic [31:0] in_paddr,
  input  logic [11:0] in_page_flags,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_addr,
  output logic        out_frame_freed,
  output logic        out_pool_empty
);

  logic [1:0]        kind_r;
  logic [31:0]       va_r;
  logic [31:0]       pa_r;
  logic [11:0]       flags_r;
  logic [SLOT_W-1:0] slot_r;
  logic [USED_W-1:0] used_r;
  logic [IDX_W-1:0]  cnt_r;
  logic              out_valid_r;
  logic [31:0]       res_addr_r;
  logic              res_freed_r;
  logic              res_empty_r;
  logic [31:0]       out_addr_r;
  logic              out_freed_r;
  logic              out_empty_r;

  dir_ent_t          dir_mem [DIR_ENTRIES];
  dir_ent_t          dir_q;
  dir_ent_t          dir_wdata;
  logic [IDX_W-1:0]  dir_waddr;
  logic [31:0]       tbl_mem [TBL_DEPTH];
  logic [31:0]       tbl_q;
  logic [TBL_AW-1:0] tbl_addr;
  logic [31:0]       tbl_wdata;
  logic              pool_full;

  assign pool_full = used_r >= USED_W'(TABLE_POOL);
  assign dir_waddr = cmd.dir_init ? cnt_r : va_r[31:22];
  assign dir_wdata = cmd.dir_init ? dir_ent_t'('0)
                                  : dir_ent_t'{present: 1'b1, slot: used_r[SLOT_W-1:0]};
  assign tbl_addr  = {slot_r, (cmd.tbl_sweep ? cnt_r : va_r[21:12])};
  assign tbl_wdata = cmd.tbl_map ? ((pa_r & FRAME_MASK) | {20'd0, flags_r | ENTRY_PRESENT})
                                 : '0;

  always_ff @(posedge clk) begin
    if (cmd.dir_init || cmd.alloc) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (cmd.capture) begin
      dir_q <= dir_mem[in_vaddr[31:22]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) begin
      tbl_mem[tbl_addr] <= tbl_wdata;
    end
    if (cmd.tbl_rd) begin
      tbl_q <= tbl_mem[tbl_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      va_r    <= in_vaddr;
      pa_r    <= in_paddr;
      flags_r <= in_page_flags;
    end
    if (cmd.slot_ld) begin
      slot_r <= dir_q.present ? dir_q.slot : used_r[SLOT_W-1:0];
    end
    if (cmd.res_ld) begin
      case (cmd.res_sel)
        RES_EMPTY: begin
          res_addr_r  <= '0;
          res_freed_r <= 1'b0;
          res_empty_r <= 1'b1;
        end
        RES_XLATE: begin
          res_addr_r  <= tbl_q[0] ? ((tbl_q & FRAME_MASK) | (va_r & OFFSET_MASK)) : '0;
          res_freed_r <= 1'b0;
          res_empty_r <= 1'b0;
        end
        RES_UNMAP: begin
          res_addr_r  <= tbl_q & FRAME_MASK;
          res_freed_r <= |(tbl_q & FRAME_MASK);
          res_empty_r <= 1'b0;
        end
        default: begin
          res_addr_r  <= '0;
          res_freed_r <= 1'b0;
          res_empty_r <= 1'b0;
        end
      endcase
    end
    if (cmd.out_ld) begin
      out_addr_r  <= res_addr_r;
      out_freed_r <= res_freed_r;
      out_empty_r <= res_empty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.alloc) begin
        used_r <= used_r + USED_W'(1);
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.kind        = kind_r;
  assign sts.dir_present = dir_q.present;
  assign sts.pool_full   = pool_full;
  assign sts.cnt_last    = &cnt_r;
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_result_addr = out_addr_r;
  assign out_frame_freed = out_freed_r;
  assign out_pool_empty  = out_empty_r;

  // The pool count never passes the number of tables in the pool.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(TABLE_POOL))
    else $error("page table pool count overflow");

  // A result is never loaded over one that is still waiting.
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  // Sweep beats only write zeros.
  a_sweep_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tbl_sweep |-> (cmd.tbl_wr && !cmd.tbl_map))
    else $error("sweep beat without zero write");

endmodule

>>> rtl/tlpt_ctrl.sv
// Controller: sequences directory clearing, directory read, table allocation and sweep,
// table read and write-back, and result delivery. Depends on tlpt_pkg.
module tlpt_ctrl
  import tlpt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tlpt_sts_t sts,
  output tlpt_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DIR,
    S_SWEEP,
    S_MAPW,
    S_RD,
    S_TBL,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.dir_init = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DIR;
        end
      end
      S_DIR: begin
        cmd.slot_ld = 1'b1;
        unique case (sts.kind) inside
          KIND_XLATE: begin
            if (sts.dir_present) begin
              state_nxt = S_RD;
            end else begin
              cmd.res_ld  = 1'b1;
              cmd.res_sel = RES_ZERO;
              state_nxt   = S_DONE;
            end
          end
          KIND_MAP, KIND_UNMAP: begin
            if (sts.dir_present) begin
              state_nxt = (sts.kind == KIND_MAP) ? S_MAPW : S_RD;
            end else if (sts.pool_full) begin
              cmd.res_ld  = 1'b1;
              cmd.res_sel = RES_EMPTY;
              state_nxt   = S_DONE;
            end else begin
              cmd.alloc   = 1'b1;
              cmd.cnt_clr = 1'b1;
              state_nxt   = S_SWEEP;
            end
          end
          default: begin
            cmd.res_ld  = 1'b1;
            cmd.res_sel = RES_ZERO;
            state_nxt   = S_DONE;
          end
        endcase
      end
      S_SWEEP: begin
        cmd.tbl_wr    = 1'b1;
        cmd.tbl_sweep = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (sts.cnt_last) begin
          if (sts.kind == KIND_MAP) begin
            state_nxt = S_MAPW;
          end else begin
            cmd.res_ld  = 1'b1;
            cmd.res_sel = RES_ZERO;
            state_nxt   = S_DONE;
          end
        end
      end
      S_MAPW: begin
        cmd.tbl_wr  = 1'b1;
        cmd.tbl_map = 1'b1;
        cmd.res_ld  = 1'b1;
        cmd.res_sel = RES_ZERO;
        state_nxt   = S_DONE;
      end
      S_RD: begin
        cmd.tbl_rd = 1'b1;
        state_nxt  = S_TBL;
      end
      S_TBL: begin
        cmd.res_ld = 1'b1;
        if (sts.kind == KIND_UNMAP) begin
          cmd.tbl_wr  = 1'b1;
          cmd.res_sel = RES_UNMAP;
        end else begin
          cmd.res_sel = RES_XLATE;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An accepted beat always starts with the directory lookup.
  a_accept_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DIR))
    else $error("accepted request did not start a directory lookup");

  // A table is only taken for an absent directory entry while the pool has room.
  a_alloc_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> (!sts.pool_full && !sts.dir_present))
    else $error("illegal page table allocation");

endmodule

>>> rtl/two_level_page_table_engine.sv
// Two-level 10/10/12 page table engine: top level joining controller,
// datapath and the channel interfaces. Depends on tlpt_pkg, tlpt_if,
// tlpt_ctrl and tlpt_datapath.
//
// Requests arrive on in_chan (translate, map or unmap) and each produces
// exactly one result beat on out_chan. One request is worked on at a time.
// After a synchronous reset the directory is cleared by a pass over all its
// entries, during which in_chan.ready stays low.
// An unused kind, a pool-empty request or a translate with no directory
// entry finishes after the directory lookup without a table access; a map
// writes the page entry and a translate or unmap reads it. A map or unmap
// that takes a new table first sweeps it to zero, one entry a cycle.
// The directory read and the dependent table read are registered, and a
// result passes a result register before the output register.
// With a ready receiver the next request can be accepted in the same
// cycle that the result turns valid.
// A stalled receiver holds the result in the output register; the next
// request is still worked on and then waits in its final state.
module two_level_page_table_engine
  import tlpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  tlpt_req_if.sink   in_chan,
  tlpt_rsp_if.source out_chan
);

  tlpt_cmd_t cmd;
  tlpt_sts_t sts;
  logic      ctl_ready;

  assign in_chan.ready = ctl_ready;

  tlpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (ctl_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlpt_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_chan.kind),
    .in_vaddr        (in_chan.vaddr),
    .in_paddr        (in_chan.paddr),
    .in_page_flags   (in_chan.page_flags),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_result_addr (out_chan.result_addr),
    .out_frame_freed (out_chan.frame_freed),
    .out_pool_empty  (out_chan.pool_empty)
  );

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the two-level page table engine: a behavioral page walk
// predicts every result beat, which is checked field by field against the block's output.
// Depends on tlpt_pkg, tlpt_if and the engine RTL.
module testbench;
  import tlpt_pkg::*;

  localparam logic [1:0] KIND_RSVD = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [31:0] addr;
    logic        freed;
    logic        empty;
  } walk_result_t;

  logic clk;
  logic rst_n;

  tlpt_req_if req_chan ();
  tlpt_rsp_if rsp_chan ();

  two_level_page_table_engine uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (req_chan),
    .out_chan(rsp_chan)
  );

  logic              dir_valid [DIR_ENTRIES];
  logic [SLOT_W-1:0] dir_slot [DIR_ENTRIES];
  logic [31:0]       pte_mem [TBL_DEPTH];
  int unsigned       tables_taken;
  logic [9:0]        mapped_dirs [$];
  logic [9:0]        hot_idx [8];

  walk_result_t pending_results [$];
  int mismatch_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_seen;
  int hold_left;
  int cycle_count;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch: %s", msg);
  endtask

  // Finds the page entry for va, taking a cleared table from the pool when the
  // directory entry is absent. Returns 0 when the pool is exhausted.
  function automatic bit claim_entry(input logic [31:0] va, output int pos);
    logic [9:0] d;
    d = va[31:22];
    pos = 0;
    if (!dir_valid[d]) begin
      if (tables_taken >= TABLE_POOL) return 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) pte_mem[tables_taken * TABLE_ENTRIES + i] = '0;
      dir_slot[d] = tables_taken[SLOT_W-1:0];
      dir_valid[d] = 1'b1;
      tables_taken++;
      mapped_dirs.push_back(d);
    end
    pos = int'(dir_slot[d]) * TABLE_ENTRIES + int'(va[21:12]);
    return 1;
  endfunction

  function automatic walk_result_t predict_walk(input logic [1:0] kind, input logic [31:0] va,
                                                input logic [31:0] pa, input logic [11:0] flags);
    walk_result_t r;
    int pos;
    r = '0;
    case (kind)
      KIND_XLATE: begin
        if (dir_valid[va[31:22]]) begin
          pos = int'(dir_slot[va[31:22]]) * TABLE_ENTRIES + int'(va[21:12]);
          if ((pte_mem[pos] & {20'd0, ENTRY_PRESENT}) != 0)
            r.addr = (pte_mem[pos] & FRAME_MASK) | (va & OFFSET_MASK);
        end
      end
      KIND_MAP: begin
        if (claim_entry(va, pos))
          pte_mem[pos] = (pa & FRAME_MASK) | {20'd0, flags | ENTRY_PRESENT};
        else r.empty = 1'b1;
      end
      KIND_UNMAP: begin
        if (claim_entry(va, pos)) begin
          r.addr = pte_mem[pos] & FRAME_MASK;
          r.freed = (r.addr != 0);
          pte_mem[pos] = '0;
        end else begin
          r.empty = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offers one request beat, with random idle cycles ahead of it, and records
  // the predicted result once the block takes it.
  task automatic send_req(input logic [1:0] kind, input logic [31:0] va, input logic [31:0] pa,
                          input logic [11:0] flags);
    while ($urandom_range(99) < send_idle_pct) begin
      req_chan.valid <= 1'b0;
      @(posedge clk);
    end
    req_chan.valid      <= 1'b1;
    req_chan.kind       <= kind;
    req_chan.vaddr      <= va;
    req_chan.paddr      <= pa;
    req_chan.page_flags <= flags;
    do @(posedge clk); while (!req_chan.ready);
    pending_results.push_back(predict_walk(kind, va, pa, flags));
  endtask

  task automatic send_random_req();
    logic [1:0] kind;
    logic [9:0] d;
    logic [9:0] t;
    logic [11:0] offs;
    logic [11:0] flags;
    logic [31:0] pa;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) kind = KIND_XLATE;
    else if (roll < 75) kind = KIND_MAP;
    else if (roll < 95) kind = KIND_UNMAP;
    else kind = KIND_RSVD;
    if (mapped_dirs.size() != 0 && $urandom_range(99) < 85)
      d = mapped_dirs[$urandom_range(mapped_dirs.size() - 1)];
    else
      d = 10'($urandom_range(DIR_ENTRIES - 1));
    if ($urandom_range(99) < 70) t = hot_idx[$urandom_range(7)];
    else t = 10'($urandom_range(TABLE_ENTRIES - 1));
    offs = 12'($urandom_range(4095));
    flags = 12'($urandom_range(4095));
    pa = $urandom;
    send_req(kind, {d, t, offs}, pa, flags);
  endtask

  task automatic send_random_burst(input int n);
    for (int i = 0; i < n; i++) send_random_req();
  endtask

  task automatic wait_all_results();
    req_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_chan.ready <= 1'b0;
    end else begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    walk_result_t want;
    if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (rsp_chan.result_addr !== want.addr)
          report_mismatch($sformatf("result_addr %h, expected %h",
                                    rsp_chan.result_addr, want.addr));
        if (rsp_chan.frame_freed !== want.freed)
          report_mismatch($sformatf("frame_freed %b, expected %b",
                                    rsp_chan.frame_freed, want.freed));
        if (rsp_chan.pool_empty !== want.empty)
          report_mismatch($sformatf("pool_empty %b, expected %b",
                                    rsp_chan.pool_empty, want.empty));
      end
    end
  end

  task automatic test_directed();
    send_req(KIND_XLATE, 32'h0000_0000, 32'h0, 12'h000);
    send_req(KIND_XLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    send_req(KIND_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    send_req(KIND_MAP, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
    send_req(KIND_XLATE, 32'h0000_0FFF, 32'h0, 12'h000);
    send_req(KIND_MAP, 32'hFFFF_FFFF, 32'h0000_0000, 12'h000);
    send_req(KIND_XLATE, 32'hFFFF_FABC, 32'h0, 12'h000);
    send_req(KIND_UNMAP, 32'hFFFF_F000, 32'h0, 12'h000);
    send_req(KIND_XLATE, 32'hFFFF_F123, 32'h0, 12'h000);
    send_req(KIND_UNMAP, 32'h0000_0000, 32'h0, 12'h000);
    send_req(KIND_UNMAP, 32'h0000_0000, 32'h0, 12'h000);
    send_req(KIND_MAP, 32'h0000_1000, 32'h1234_5678, 12'h002);
    send_req(KIND_XLATE, 32'h0000_1ABC, 32'h0, 12'h000);
    send_req(KIND_MAP, 32'h0000_1000, 32'hABCD_E000, 12'h800);
    send_req(KIND_XLATE, 32'h0000_1FFF, 32'h0, 12'h000);
    send_req(KIND_UNMAP, 32'h0040_0000, 32'h0, 12'h000);
    send_req(KIND_XLATE, 32'h0040_0000, 32'h0, 12'h000);
    send_req(KIND_XLATE, 32'h003F_F000, 32'h0, 12'h000);
    send_req(KIND_MAP, 32'h003F_F000, 32'h8000_0000, 12'h555);
    send_req(KIND_XLATE, 32'h003F_FAAA, 32'h0, 12'h000);
    send_req(KIND_UNMAP, 32'h003F_F000, 32'h0, 12'h000);
    send_req(KIND_RSVD, 32'h0, 32'h0, 12'h000);
    wait_all_results();
  endtask

  task automatic test_no_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random_burst(150);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 55;
    recv_stall_pct = 0;
    send_random_burst(150);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    recv_stall_pct = 55;
    send_random_burst(150);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 15;
    recv_stall_pct = 15;
    send_random_burst(150);
  endtask

  // The receiver refuses every beat for a long stretch while requests keep
  // coming, so the block backs up and holds its input off.
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req <= hold_req + 1;
    send_random_burst(30);
    wait_all_results();
  endtask

  task automatic test_drained_restart();
    send_idle_pct = 15;
    recv_stall_pct = 15;
    for (int i = 0; i < 4; i++) begin
      send_random_burst(25);
      wait_all_results();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    req_chan.valid = 1'b0;
    req_chan.kind = KIND_XLATE;
    req_chan.vaddr = '0;
    req_chan.paddr = '0;
    req_chan.page_flags = '0;
    rsp_chan.ready = 1'b0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    cycle_count = 0;
    tables_taken = 0;
    foreach (dir_valid[i]) dir_valid[i] = 1'b0;
    foreach (dir_slot[i]) dir_slot[i] = '0;
    foreach (pte_mem[i]) pte_mem[i] = '0;
    hot_idx[0] = 10'd0;
    hot_idx[1] = 10'd1023;
    for (int i = 2; i < 8; i++) hot_idx[i] = 10'($urandom_range(TABLE_ENTRIES - 1));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_output_hold();
    test_drained_restart();

    wait_all_results();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) report_mismatch("expected results never arrived");
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tlpt_pkg.sv
rtl/tlpt_if.sv
rtl/tlpt_datapath.sv
rtl/tlpt_ctrl.sv
rtl/two_level_page_table_engine.sv
sim/testbench.sv
